FILE: rtl/core/sdf_pkg.sv
package sdf_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam int VALUE_W   = 32;
    localparam int PREC_W    = 6;
    localparam int LEN_W     = 6;
    localparam int DIGIT_W   = 4;
    localparam int NUM_DIGITS = 10;
    localparam int NDIG_W    = 4;

    // m / 10 == (m * RECIP_TEN) >> RECIP_SHIFT for every 32-bit m
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam logic [VALUE_W-1:0] TEN         = 32'd10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One formatted value, ready for character emission
    typedef struct packed {
        logic [7:0]                      sign_char;
        logic                            has_sign;
        logic [PREC_W-1:0]               pad;
        logic [NUM_DIGITS*DIGIT_W-1:0]   digits;   // most significant in [3:0]
        logic [LEN_W-1:0]                total;
    } sdf_entry_t;

    typedef enum logic [2:0] {
        FR_IDLE = 3'b001,
        FR_CONV = 3'b010,
        FR_PUSH = 3'b100
    } sdf_front_state_t;

endpackage

FILE: rtl/core/sdf_channels.sv
interface sdf_num_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [5:0]  precision;
    logic        precision_given;
    logic        plus_sign;
    logic        space_sign;

    modport source (output valid, value, precision, precision_given, plus_sign, space_sign,
                    input ready);
    modport sink   (input valid, value, precision, precision_given, plus_sign, space_sign,
                    output ready);
endinterface

interface sdf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;
    logic [5:0] total_len;

    modport source (output valid, char_out, last, total_len, input ready);
    modport sink   (input valid, char_out, last, total_len, output ready);
endinterface

FILE: rtl/core/sdf_front.sv
module sdf_front #(
    parameter int MAX_PRECISION = 62
) (
    input  logic                clk,
    input  logic                rst_n,
    sdf_num_if.sink             num,
    output logic                push,
    output sdf_pkg::sdf_entry_t push_entry,
    input  logic                full
);

    localparam logic [sdf_pkg::PREC_W-1:0] MAX_PREC = sdf_pkg::PREC_W'(MAX_PRECISION);
    localparam int DW = sdf_pkg::NUM_DIGITS * sdf_pkg::DIGIT_W;

    sdf_pkg::sdf_front_state_t state_reg, state_next;

    logic [63:0]                   prod_reg;
    logic [31:0]                   mag_reg;
    logic [DW-1:0]                 dig_reg;
    logic [sdf_pkg::NDIG_W-1:0]    ndig_reg;
    logic [sdf_pkg::PREC_W-1:0]    prec_reg;
    logic [7:0]                    sign_char_reg;
    logic                          has_sign_reg;
    logic                          suppress_reg;

    logic                          accept;
    logic [31:0]                   mag_in;
    logic [sdf_pkg::PREC_W-1:0]    prec_in;
    logic [31:0]                   quot;
    logic [31:0]                   rem;
    logic [31:0]                   mult_a;
    logic [63:0]                   prod_next;
    logic [sdf_pkg::PREC_W-1:0]    ndig_eff;
    logic [sdf_pkg::PREC_W-1:0]    pad;
    logic [sdf_pkg::LEN_W-1:0]     total;

    assign num.ready = (state_reg == sdf_pkg::FR_IDLE);
    assign accept    = num.valid && num.ready;

    assign mag_in  = num.value[31] ? (~num.value + 32'd1) : num.value;
    assign prec_in = !num.precision_given ? sdf_pkg::PREC_W'(1)
                   : (num.precision > MAX_PREC) ? MAX_PREC : num.precision;

    // quotient by ten is a bit slice of the registered product
    assign quot = {3'b000, prod_reg[63:sdf_pkg::RECIP_SHIFT]};
    assign rem  = mag_reg - ((quot << 3) + (quot << 1));

    assign mult_a    = accept ? mag_in : quot;
    assign prod_next = {32'd0, mult_a} * {32'd0, sdf_pkg::RECIP_TEN};

    assign ndig_eff = suppress_reg ? '0 : sdf_pkg::PREC_W'(ndig_reg);
    assign pad      = (prec_reg > ndig_eff) ? (prec_reg - ndig_eff) : '0;
    assign total    = sdf_pkg::LEN_W'(has_sign_reg) + pad + ndig_eff;

    always_comb
    begin
        push_entry.sign_char = sign_char_reg;
        push_entry.has_sign  = has_sign_reg;
        push_entry.pad       = pad;
        push_entry.digits    = dig_reg;
        push_entry.total     = total;
    end

    assign push = (state_reg == sdf_pkg::FR_PUSH) && !full && (total != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdf_pkg::FR_IDLE: if (accept) state_next = sdf_pkg::FR_CONV;
            sdf_pkg::FR_CONV: if (quot == '0) state_next = sdf_pkg::FR_PUSH;
            sdf_pkg::FR_PUSH: if (total == '0 || !full) state_next = sdf_pkg::FR_IDLE;
            default:          state_next = sdf_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdf_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath: load on transfer, then one digit per cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg     <= prod_next;
            mag_reg      <= mag_in;
            ndig_reg     <= '0;
            prec_reg     <= prec_in;
            suppress_reg <= (prec_in == '0) && (mag_in == '0);
            has_sign_reg <= num.value[31] || num.plus_sign || num.space_sign;
            sign_char_reg <= num.value[31] ? sdf_pkg::CHAR_MINUS
                           : num.plus_sign ? sdf_pkg::CHAR_PLUS : sdf_pkg::CHAR_SPACE;
        end
        else if (state_reg == sdf_pkg::FR_CONV)
        begin
            dig_reg  <= {dig_reg[DW-sdf_pkg::DIGIT_W-1:0], rem[sdf_pkg::DIGIT_W-1:0]};
            ndig_reg <= ndig_reg + 1'b1;
            mag_reg  <= quot;
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: rtl/core/sdf_queue.sv
module sdf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sdf_pkg::sdf_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output sdf_pkg::sdf_entry_t head
);

    localparam int CNT_W = $clog2(sdf_pkg::QUEUE_DEPTH + 1);

    sdf_pkg::sdf_entry_t           entry_reg [sdf_pkg::QUEUE_DEPTH];
    logic [sdf_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sdf_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]              count_reg;

    assign full  = (count_reg == CNT_W'(sdf_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == sdf_pkg::QPTR_W'(sdf_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == sdf_pkg::QPTR_W'(sdf_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/core/sdf_emitter.sv
module sdf_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  sdf_pkg::sdf_entry_t head,
    output logic                pop,
    sdf_char_if.source          chars
);

    localparam int DW = sdf_pkg::NUM_DIGITS * sdf_pkg::DIGIT_W;

    logic                          busy_reg;
    logic                          sign_pend_reg;
    logic [sdf_pkg::PREC_W-1:0]    pad_reg;
    logic [DW-1:0]                 dig_reg;
    logic [sdf_pkg::LEN_W-1:0]     rem_reg;
    logic [sdf_pkg::LEN_W-1:0]     total_reg;
    logic [7:0]                    sign_char_reg;

    logic                          out_valid_reg;
    logic [7:0]                    out_char_reg;
    logic                          out_last_reg;
    logic [sdf_pkg::LEN_W-1:0]     out_len_reg;

    logic                          load;
    logic                          finish;
    logic                          is_last;
    logic [7:0]                    cur_char;

    assign load    = busy_reg && (!out_valid_reg || chars.ready);
    assign is_last = (rem_reg == sdf_pkg::LEN_W'(1));
    assign finish  = load && is_last;
    assign pop     = valid && (!busy_reg || finish);

    always_comb
    begin
        if (sign_pend_reg)
        begin
            cur_char = sign_char_reg;
        end
        else if (pad_reg != '0)
        begin
            cur_char = sdf_pkg::CHAR_ZERO;
        end
        else
        begin
            cur_char = sdf_pkg::CHAR_ZERO + {4'h0, dig_reg[sdf_pkg::DIGIT_W-1:0]};
        end
    end

    assign chars.valid     = out_valid_reg;
    assign chars.char_out  = out_char_reg;
    assign chars.last      = out_last_reg;
    assign chars.total_len = out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg || finish)
            begin
                busy_reg <= valid;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chars.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sign_pend_reg <= head.has_sign;
            sign_char_reg <= head.sign_char;
            pad_reg       <= head.pad;
            dig_reg       <= head.digits;
            rem_reg       <= head.total;
            total_reg     <= head.total;
        end
        else if (load)
        begin
            rem_reg <= rem_reg - 1'b1;
            if (sign_pend_reg)
            begin
                sign_pend_reg <= 1'b0;
            end
            else if (pad_reg != '0)
            begin
                pad_reg <= pad_reg - 1'b1;
            end
            else
            begin
                dig_reg <= {{sdf_pkg::DIGIT_W{1'b0}}, dig_reg[DW-1:sdf_pkg::DIGIT_W]};
            end
        end

        if (load)
        begin
            out_char_reg <= cur_char;
            out_last_reg <= is_last;
            out_len_reg  <= is_last ? total_reg : '0;
        end
    end

endmodule

FILE: rtl/core/signed_decimal_formatter.sv
// Channel  Role    Payload                                                 Transfer
// num      sink    value, precision, precision_given, plus_sign, space_sign  valid & ready
// chars    source  char_out, last, total_len                               valid & ready
//
// Front: accepts a value only while idle; D = decimal digits of the magnitude (1..10).
// It takes no new value until the divide-by-ten multiply loop, one digit per cycle, has
// yielded all D digits and its push state is over. Back: one character per cycle while chars
// is ready; optional sign + max(precision, D) characters per value, no digits for zero at precision 0.
// rst_n clears the control state asynchronously; payload registers are not reset.
// A stall on chars holds the back; the two-entry queue lets the front keep converting.
module signed_decimal_formatter #(
    parameter int MAX_PRECISION = 62
) (
    input  logic        clk,
    input  logic        rst_n,
    sdf_num_if.sink     num,
    sdf_char_if.source  chars
);

    // front to queue
    logic                push;
    sdf_pkg::sdf_entry_t push_entry;
    logic                full;

    // queue to back
    logic                pop;
    logic                head_valid;
    sdf_pkg::sdf_entry_t head;

    // Classify the item, saturate precision and peel off digits by
    // reciprocal multiply; push one record per value that prints anything.
    sdf_front #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .num        (num),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    // Decouple conversion from emission.
    sdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .valid      (head_valid),
        .head       (head)
    );

    // Walk sign, pad zeros and digits out through a registered output stage.
    sdf_emitter u_emitter (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (head_valid),
        .head  (head),
        .pop   (pop),
        .chars (chars)
    );

endmodule

FILE: rtl/core/sdf_checker.sv
module sdf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       chars_valid,
    input logic       chars_ready,
    input logic [7:0] char_out,
    input logic       last,
    input logic [5:0] total_len
);

    // hold a stalled character
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid && !chars_ready |=> chars_valid)
        else $error("chars valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid && !chars_ready |=>
            $stable(char_out) && $stable(last) && $stable(total_len))
        else $error("chars payload changed while stalled");

    a_len_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid && !last |-> total_len == 6'd0)
        else $error("total_len set on a character that is not last");

    a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid && last |-> total_len != 6'd0)
        else $error("zero total_len on last character");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid |->
            (char_out >= sdf_pkg::CHAR_ZERO && char_out <= sdf_pkg::CHAR_NINE) ||
            char_out == sdf_pkg::CHAR_MINUS || char_out == sdf_pkg::CHAR_PLUS ||
            char_out == sdf_pkg::CHAR_SPACE)
        else $error("character outside sign and digit set");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .chars_valid (chars.valid),
    .chars_ready (chars.ready),
    .char_out    (chars.char_out),
    .last        (chars.last),
    .total_len   (chars.total_len)
);

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Block configuration and run shape
    localparam int MAX_PREC       = 62;
    localparam int MAX_CHARS      = 64;
    localparam int RANDOM_ITEMS   = 340;
    // Random item index at which the receiver starts its long hold-off
    localparam int HOLD_AT        = 80;
    // Random item index at which the sender waits for the output to drain
    localparam int PAUSE_AT       = 200;
    localparam int LONG_HOLD      = 400;
    // A value has at most 10 digits to convert and 63 characters to emit;
    // allow a generous margin for stray characters after the last one.
    localparam int DRAIN_CYCLES   = 150;
    // Longest correct silence is the long hold-off plus one conversion.
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  precision;
        logic        precision_given;
        logic        plus_sign;
        logic        space_sign;
    } num_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [5:0] len;
    } char_exp_t;

    logic clk;
    logic rst_n;

    sdf_num_if  num();
    sdf_char_if chars();

    signed_decimal_formatter #(
        .MAX_PRECISION(MAX_PREC)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num),
        .chars (chars)
    );

    // Characters still owed by the block, oldest first
    char_exp_t expected_chars[$];

    // Directed table: stimulus, literal text, and whether that text is typed in
    num_item_t dir_items[$];
    string     dir_text[$];
    bit        dir_typed[$];

    int errors;
    int chars_checked;
    int items_sent;
    int silent_items;
    int longest_text;
    int idle_cycles;
    bit hold_off_req;

    // Free-running clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Append one row to the directed table. Leave txt empty and typed low
    // to have the row checked against the formatter model instead.
    function automatic void add_row(input logic [31:0] v, input int p, input bit g,
                                    input bit pl, input bit sp, input string txt,
                                    input bit typed);
        num_item_t it;
        it.value           = v;
        it.precision       = p[5:0];
        it.precision_given = g;
        it.plus_sign       = pl;
        it.space_sign      = sp;
        dir_items.push_back(it);
        dir_text.push_back(txt);
        dir_typed.push_back(typed);
    endfunction

    // Format one value the way printf renders %d with flags and precision:
    // sign first, then zero padding up to the precision, then the digits.
    function automatic void format_decimal(input num_item_t it,
                                           output logic [7:0] txt [MAX_CHARS],
                                           output int n);
        logic        neg;
        logic [31:0] mag;
        logic [3:0]  dig [10];
        int          prec;
        int          ndig;
        int          i;
        n    = 0;
        ndig = 0;
        for (i = 0; i < MAX_CHARS; i++)
        begin
            txt[i] = '0;
        end
        neg = it.value[31];
        // Two's complement negate; the most negative value maps onto 2^31
        // in unsigned arithmetic with no overflow.
        mag = neg ? (32'd0 - it.value) : it.value;
        // Ignore the precision field unless given; saturate at the limit.
        prec = it.precision_given ? int'(it.precision) : 1;
        if (prec > MAX_PREC)
        begin
            prec = MAX_PREC;
        end
        // Minus wins for negatives; plus beats space for everything else.
        if (neg)
        begin
            txt[n] = sdf_pkg::CHAR_MINUS;
            n++;
        end
        else if (it.plus_sign)
        begin
            txt[n] = sdf_pkg::CHAR_PLUS;
            n++;
        end
        else if (it.space_sign)
        begin
            txt[n] = sdf_pkg::CHAR_SPACE;
            n++;
        end
        // Zero with an explicit zero precision prints no digits at all.
        if (!(prec == 0 && mag == 0))
        begin
            do
            begin
                dig[ndig] = 4'(mag % 10);
                mag       = mag / 10;
                ndig++;
            end
            while (mag != 0);
            for (i = 0; i < prec - ndig; i++)
            begin
                txt[n] = sdf_pkg::CHAR_ZERO;
                n++;
            end
            for (i = ndig - 1; i >= 0; i--)
            begin
                txt[n] = sdf_pkg::CHAR_ZERO + 8'(dig[i]);
                n++;
            end
        end
    endfunction

    // Sender: reset, the directed table, then random values in bursts.
    initial
    begin
        num_item_t        it;
        logic [7:0]       txt [MAX_CHARS];
        logic [31:0]      p10;
        string            s;
        char_exp_t        e;
        int               n;
        int               i;
        int               idx;
        int               total;
        int               dir_n;
        int               burst_left;
        int               gap;
        int               sel;

        // Drive every input to a known value from time zero.
        rst_n                <= 1'b0;
        num.valid            <= 1'b0;
        num.value            <= '0;
        num.precision        <= '0;
        num.precision_given  <= 1'b0;
        num.plus_sign        <= 1'b0;
        num.space_sign       <= 1'b0;

        // Directed table: literal text where it reads straight off the rules.
        add_row(32'd0,          0,  1'b0, 1'b0, 1'b0, "0",            1'b1);
        add_row(32'd0,          0,  1'b1, 1'b0, 1'b0, "",             1'b1);
        add_row(32'd0,          0,  1'b1, 1'b1, 1'b0, "+",            1'b1);
        add_row(32'd0,          0,  1'b1, 1'b0, 1'b1, " ",            1'b1);
        add_row(32'd0,          0,  1'b1, 1'b1, 1'b1, "+",            1'b1);
        add_row(32'h8000_0000,  0,  1'b0, 1'b0, 1'b0, "-2147483648",  1'b1);
        add_row(32'h7FFF_FFFF,  0,  1'b0, 1'b0, 1'b0, "2147483647",   1'b1);
        add_row(32'h7FFF_FFFF,  0,  1'b0, 1'b1, 1'b1, "+2147483647",  1'b1);
        add_row(32'hFFFF_FFFF,  0,  1'b0, 1'b1, 1'b0, "-1",           1'b1);
        add_row(32'd5,          0,  1'b0, 1'b0, 1'b1, " 5",           1'b1);
        add_row(32'd123,        5,  1'b1, 1'b0, 1'b0, "00123",        1'b1);
        add_row(32'd123,        40, 1'b0, 1'b0, 1'b0, "123",          1'b1);
        add_row(32'd9,          0,  1'b1, 1'b0, 1'b0, "9",            1'b1);
        add_row(32'd10,         0,  1'b0, 1'b0, 1'b0, "10",           1'b1);
        // Padding and saturation rows go through the model.
        add_row(32'd7,          63, 1'b1, 1'b0, 1'b0, "",             1'b0);
        add_row(-32'sd42,       62, 1'b1, 1'b1, 1'b0, "",             1'b0);
        add_row(32'd1000000000, 10, 1'b1, 1'b0, 1'b1, "",             1'b0);
        add_row(32'd0,          63, 1'b1, 1'b0, 1'b1, "",             1'b0);
        add_row(32'h8000_0000,  63, 1'b1, 1'b1, 1'b1, "",             1'b0);
        add_row(32'd999999999,  9,  1'b1, 1'b1, 1'b0, "",             1'b0);
        add_row(32'd0,          42, 1'b0, 1'b0, 1'b0, "",             1'b0);

        dir_n      = dir_items.size();
        total      = dir_n + RANDOM_ITEMS;
        burst_left = 0;

        // Hold reset, then release it on a falling edge, away from the rising edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (idx = 0; idx < total; idx++)
        begin
            if (idx < dir_n)
            begin
                it = dir_items[idx];
            end
            else
            begin
                // Mix full-range, small, zero, decade-edge and extreme values.
                sel = $urandom_range(0, 5);
                case (sel)
                    0: it.value = $urandom;
                    1: it.value = $urandom_range(0, 99);
                    2: it.value = '0;
                    3:
                    begin
                        p10 = 32'd1;
                        repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                        it.value = p10 - $urandom_range(0, 1);
                    end
                    4:
                    begin
                        case ($urandom_range(0, 3))
                            0:       it.value = 32'h8000_0000;
                            1:       it.value = 32'h7FFF_FFFF;
                            2:       it.value = 32'hFFFF_FFFF;
                            default: it.value = 32'd1;
                        endcase
                    end
                    default: it.value = $urandom >> $urandom_range(0, 31);
                endcase
                if (sel != 4 && $urandom_range(0, 1) == 1)
                begin
                    it.value = 32'd0 - it.value;
                end
                // Keep most precisions short so values stay near 11 characters.
                it.precision_given = 1'($urandom_range(0, 1));
                it.precision       = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                                  : 6'($urandom_range(0, 12));
                if (it.value == 0 && $urandom_range(0, 3) == 0)
                begin
                    it.precision = '0;
                end
                it.plus_sign  = 1'($urandom_range(0, 1));
                it.space_sign = 1'($urandom_range(0, 1));
            end

            // Drop valid and wait for every owed character once mid-run.
            if (idx == dir_n + PAUSE_AT)
            begin
                num.valid <= 1'b0;
                do
                begin
                    @(negedge clk);
                end
                while (expected_chars.size() != 0);
            end

            // Start a new burst, with a random gap before it most of the time.
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    num.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;

            // Offer the value and hold it until the transfer happens.
            num.valid           <= 1'b1;
            num.value           <= it.value;
            num.precision       <= it.precision;
            num.precision_given <= it.precision_given;
            num.plus_sign       <= it.plus_sign;
            num.space_sign      <= it.space_sign;
            do
            begin
                @(posedge clk);
            end
            while (!num.ready);

            // Transfer done: record the text this value must produce.
            if (idx < dir_n && dir_typed[idx])
            begin
                s = dir_text[idx];
                n = s.len();
                for (i = 0; i < n; i++)
                begin
                    txt[i] = s[i];
                end
            end
            else
            begin
                format_decimal(it, txt, n);
            end
            for (i = 0; i < n; i++)
            begin
                e.ch   = txt[i];
                e.last = (i == n - 1);
                e.len  = (i == n - 1) ? 6'(n) : 6'd0;
                expected_chars.push_back(e);
            end
            items_sent++;
            if (n == 0)
            begin
                silent_items++;
            end
            if (n > longest_text)
            begin
                longest_text = n;
            end

            // Ask the receiver for its long hold-off; keep offering meanwhile.
            if (idx == dir_n + HOLD_AT)
            begin
                hold_off_req = 1'b1;
            end
            @(negedge clk);
        end
        num.valid <= 1'b0;

        // Drain: wait for every owed character, then watch for strays.
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d values sent (%0d from the table), %0d characters checked",
                 items_sent, dir_n, chars_checked);
        $display("         %0d values with no text, longest text %0d characters, %0d errors",
                 silent_items, longest_text, errors);
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: change ready on falling edges, one stall pattern per segment.
    initial
    begin
        int mode;
        int seg;
        int phase;
        chars.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 4);
            seg  = $urandom_range(16, 160);
            for (phase = 0; phase < seg; phase++)
            begin
                @(negedge clk);
                // Hold off for a long stretch so the block fills and stalls its input.
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    chars.ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                end
                case (mode)
                    1:       chars.ready <= 1'($urandom_range(0, 1));
                    2:       chars.ready <= (phase % 5) != 4;
                    3:       chars.ready <= ($urandom_range(0, 5) == 0);
                    default: chars.ready <= 1'b1;
                endcase
            end
        end
    end

    // Checker: compare each character transfer with the oldest owed entry.
    always @(posedge clk)
    begin
        char_exp_t e;
        if (rst_n && chars.valid && chars.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, got 0x%02h last %0b len %0d",
                         $realtime, chars.char_out, chars.last, chars.total_len);
                errors++;
            end
            else
            begin
                e = expected_chars.pop_front();
                chars_checked++;
                if (chars.char_out !== e.ch)
                begin
                    $display("%0t: char_out mismatch: expected 0x%02h, got 0x%02h",
                             $realtime, e.ch, chars.char_out);
                    errors++;
                end
                if (chars.last !== e.last)
                begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $realtime, e.last, chars.last);
                    errors++;
                end
                if (chars.total_len !== e.len)
                begin
                    $display("%0t: total_len mismatch: expected %0d, got %0d",
                             $realtime, e.len, chars.total_len);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (num.valid && num.ready) || (chars.valid && chars.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog: no transfer for %0d cycles, %0d characters still owed",
                     $realtime, idle_cycles, expected_chars.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
